[src/firpk_pkg.sv]
// ----------------------------------------------------------------------------
// firpk_pkg
// shared constants, coefficient table and control types for the fir / peak block
// ----------------------------------------------------------------------------
package firpk_pkg;

    localparam int TAPS      = 53;
    localparam int HALF_TAPS = 27;
    localparam int TAP_W     = 6;
    localparam int SAMPLE_W  = 16;
    localparam int OUT_W     = 18;
    localparam int PEAK_W    = 15;
    localparam int TAIL_W    = 6;

    localparam int LEVEL_LIMIT = 32113;
    localparam int OUT_MAX     = 131071;
    localparam int OUT_MIN     = -131072;

    // half of the symmetric impulse response in q0.28, last entry is the center
    localparam int COEF_Q28 [HALF_TAPS] = '{
        227329, 246334, 0, -353002, -445610, 0, 722880, 913662, 0,
        -1417784, -1740298, 0, 2557125, 3068944, 0, -4366326, -5194777, 0,
        7400295, 8918995, 0, -13573194, -17497282, 0, 36447212, 73634192, 89338072
    };

    typedef struct packed {
        logic             load;
        logic             rd;
        logic             commit;
        logic [TAP_W-1:0] tap;
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_sts;

    // tap k (0 = oldest) rounded half up to q0.(bits-1), saturated to bits
    function automatic int coef_of(input int k, input int bits);
        int m;
        int s;
        int c;
        int lim;
        m = (k <= TAPS / 2) ? k : TAPS - 1 - k;
        if (m >= HALF_TAPS) begin
            m = HALF_TAPS - 1;
        end
        s   = 28 - (bits - 1);
        c   = (COEF_Q28[m] + (1 << (s - 1))) >>> s;
        lim = (1 << (bits - 1)) - 1;
        if (c > lim) begin
            c = lim;
        end
        if (c < -lim - 1) begin
            c = -lim - 1;
        end
        return c;
    endfunction

endpackage

[src/firpk_if.sv]
// ----------------------------------------------------------------------------
// firpk_in_if / firpk_out_if
// valid / ready channels carrying sample requests and filter results
// ----------------------------------------------------------------------------
interface firpk_in_if import firpk_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       chan;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;

    modport source (output valid, chan, sample, block_end, input ready);
    modport sink   (input valid, chan, sample, block_end, output ready);
endinterface

interface firpk_out_if import firpk_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    out_chan;
    logic signed [OUT_W-1:0] filtered;
    logic                    peak_valid;
    logic [PEAK_W-1:0]       peak_level;
    logic                    level_high;

    modport source (output valid, out_chan, filtered, peak_valid, peak_level, level_high,
                    input ready);
    modport sink   (input valid, out_chan, filtered, peak_valid, peak_level, level_high,
                    output ready);
endinterface

[src/firpk_ram.sv]
// ----------------------------------------------------------------------------
// firpk_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module firpk_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 106,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/firpk_ctrl.sv]
// ----------------------------------------------------------------------------
// firpk_ctrl
// sequencer: takes a request, steps the taps, waits for the mac pipe, commits
// ----------------------------------------------------------------------------
module firpk_ctrl import firpk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAPS - 1);

    logic [1:0]       r_state, n_state;
    logic [TAP_W-1:0] r_tap, n_tap;

    always_comb begin
        n_state      = r_state;
        n_tap        = r_tap;
        o_cmd.load   = 1'b0;
        o_cmd.rd     = 1'b0;
        o_cmd.commit = 1'b0;
        o_cmd.tap    = r_tap;
        o_in_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_tap      = '0;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                if (r_tap == LAST_TAP) begin
                    n_state = S_DRAIN;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register can take it
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

endmodule

[src/firpk_dp.sv]
// ----------------------------------------------------------------------------
// firpk_dp
// history ram, shared multiply-accumulate, rounding, peak meter, output register
// ----------------------------------------------------------------------------
module firpk_dp import firpk_pkg::*; #(
    parameter int CHANNELS  = 2,
    parameter int COEF_BITS = 18
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_chan,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                    i_block_end,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic                    o_out_chan,
    output logic signed [OUT_W-1:0] o_filtered,
    output logic                    o_peak_valid,
    output logic [PEAK_W-1:0]       o_peak_level,
    output logic                    o_level_high
);

    localparam int DEPTH  = CHANNELS * TAPS;
    localparam int AW     = $clog2(DEPTH);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_W = COEF_BITS + SAMPLE_W;
    localparam int ACC_W  = PROD_W + TAIL_W;
    localparam int FRAC   = COEF_BITS - 1;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(OUT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(OUT_MIN);
    localparam logic [TAP_W:0]          TAPS_X   = (TAP_W + 1)'(TAPS);
    localparam logic [TAP_W-1:0]        LAST_PTR = TAP_W'(TAPS - 1);
    localparam logic [PEAK_W-1:0]       LIMIT    = PEAK_W'(LEVEL_LIMIT);

    // current request
    logic                       r_chan;
    logic [CH_W-1:0]            r_ch;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_end;
    logic [TAP_W-1:0]           r_ptr_cur;
    logic [AW-1:0]              r_base;

    // per-channel state
    logic [TAP_W-1:0]  r_ptr  [CHANNELS];
    logic [PEAK_W-1:0] r_peak [CHANNELS];
    logic [DEPTH-1:0]  r_hvalid;

    // mac pipe
    logic                        r_v1, r_v2, r_hv1;
    logic signed [COEF_BITS-1:0] r_coef;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;

    // output register
    logic                    r_out_valid;
    logic                    r_out_chan;
    logic signed [OUT_W-1:0] r_filtered;
    logic                    r_peak_valid;
    logic [PEAK_W-1:0]       r_peak_level;
    logic                    r_level_high;

    logic [CH_W-1:0]            n_ch;
    logic [TAP_W:0]             n_idx_sum, n_idx;
    logic [AW-1:0]              n_raddr, n_waddr;
    logic [SAMPLE_W-1:0]        w_rdata;
    logic signed [SAMPLE_W-1:0] n_hdata;
    logic signed [ACC_W-1:0]    n_rnd, n_shr;
    logic signed [OUT_W-1:0]    n_filtered;
    logic [SAMPLE_W-1:0]        n_neg;
    logic [PEAK_W-1:0]          n_mag, n_peak_max;
    logic                       n_out_free;

    assign n_ch = (CHANNELS > 1) ? CH_W'(i_chan) : '0;

    // tap k reads history entry (pointer + k) mod taps, pointer marks the oldest
    assign n_idx_sum = {1'b0, r_ptr_cur} + {1'b0, i_cmd.tap};
    assign n_idx     = (n_idx_sum >= TAPS_X) ? n_idx_sum - TAPS_X : n_idx_sum;
    assign n_raddr   = r_base + AW'(n_idx);
    assign n_waddr   = r_base + AW'(r_ptr_cur);

    firpk_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (n_waddr),
        .i_wdata (r_sample),
        .i_raddr (n_raddr),
        .o_rdata (w_rdata)
    );

    // entries never written since reset read as zero
    assign n_hdata = r_hv1 ? $signed(w_rdata) : '0;

    assign n_rnd = r_acc + RND_HALF;
    assign n_shr = n_rnd >>> FRAC;

    always_comb begin
        if (n_shr > SAT_HI) begin
            n_filtered = OUT_W'(SAT_HI);
        end else if (n_shr < SAT_LO) begin
            n_filtered = OUT_W'(SAT_LO);
        end else begin
            n_filtered = n_shr[OUT_W-1:0];
        end
    end

    // magnitude with the most negative sample clipped to full scale
    assign n_neg      = (~r_sample) + 1'b1;
    assign n_mag      = r_sample[SAMPLE_W-1] ? (n_neg[SAMPLE_W-1] ? '1 : n_neg[PEAK_W-1:0])
                                             : r_sample[PEAK_W-1:0];
    assign n_peak_max = (n_mag > r_peak[r_ch]) ? n_mag : r_peak[r_ch];

    assign n_out_free      = !r_out_valid || i_out_ready;
    assign o_sts.pipe_busy = r_v1 || r_v2;
    assign o_sts.out_free  = n_out_free;

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_chan    <= i_chan;
            r_ch      <= n_ch;
            r_sample  <= i_sample;
            r_end     <= i_block_end;
            r_ptr_cur <= r_ptr[n_ch];
            r_base    <= AW'(n_ch) * AW'(TAPS);
        end
        r_coef <= COEF_BITS'(coef_of(int'(i_cmd.tap), COEF_BITS));
        r_hv1  <= r_hvalid[n_raddr];
        r_prod <= r_coef * n_hdata;
        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + {{TAIL_W{r_prod[PROD_W-1]}}, r_prod};
        end
        if (i_cmd.commit) begin
            r_out_chan <= r_chan;
            r_filtered <= n_filtered;
            r_peak_valid <= r_end;
            r_peak_level <= r_end ? n_peak_max : '0;
            r_level_high <= r_end && (n_peak_max >= LIMIT);
        end
    end

    // control and per-channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            r_hvalid    <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_ptr[c]  <= '0;
                r_peak[c] <= '0;
            end
        end else begin
            r_v1 <= i_cmd.rd;
            r_v2 <= r_v1;
            if (i_cmd.commit) begin
                r_hvalid[n_waddr] <= 1'b1;
                r_ptr[r_ch]       <= (r_ptr_cur == LAST_PTR) ? '0 : r_ptr_cur + 1'b1;
                r_peak[r_ch]      <= r_end ? '0 : n_peak_max;
                r_out_valid       <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_chan   = r_out_chan;
    assign o_filtered   = r_filtered;
    assign o_peak_valid = r_peak_valid;
    assign o_peak_level = r_peak_level;
    assign o_level_high = r_level_high;

endmodule

[src/fir_lowpass_with_peak_level.sv]
// ----------------------------------------------------------------------------
// fir_lowpass_with_peak_level
// 53-tap symmetric low-pass fir per channel with a per-channel peak meter
// ----------------------------------------------------------------------------
// usage:
// i_in carries one request: channel, signed q0.15 sample and a block-end flag.
// o_out carries one result per request: the channel, the q2.15 filter output
// over the 53 earlier samples of that channel (rounded, saturated), and on a
// block end the peak magnitude of the block with its high-level flag.
// sequence: a request is taken only in idle, after the last one is committed.
// the 53 taps go one per cycle through a single shared multiplier fed by one
// history ram read port, then the mac pipe drains and the result is committed
// as soon as the output register is free.
// reset: history reads as zero, history pointers and peaks are cleared.
// stall: a result waiting on o_out does not block the next request; it is
// accepted and computed, and only its commit waits for the output register.
// ----------------------------------------------------------------------------
module fir_lowpass_with_peak_level import firpk_pkg::*; #(
    parameter int CHANNELS  = 2,
    parameter int COEF_BITS = 18
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    firpk_in_if.sink    i_in,
    firpk_out_if.source o_out
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    firpk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    firpk_dp #(
        .CHANNELS  (CHANNELS),
        .COEF_BITS (COEF_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_chan       (i_in.chan),
        .i_sample     (i_in.sample),
        .i_block_end  (i_in.block_end),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_chan   (o_out.out_chan),
        .o_filtered   (o_out.filtered),
        .o_peak_valid (o_out.peak_valid),
        .o_peak_level (o_out.peak_level),
        .o_level_high (o_out.level_high)
    );

    assign i_in.ready = w_in_ready;

    // commit only into a free output slot
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!o_out.valid || o_out.ready))
        else $error("result committed over a pending result");

    // the ram port is never read and written for history in the same cycle
    a_no_rd_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.rd && w_cmd.commit))
        else $error("history read during commit");

    // a new request finds the mac pipe empty
    a_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> !w_sts.pipe_busy)
        else $error("request accepted with mac pipe busy");

    // after a request is taken the first tap read follows
    a_read_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (w_cmd.rd && !i_in.ready))
        else $error("tap sequence did not start");

endmodule

[bench/fir_peak_monitor.sv]
// ----------------------------------------------------------------------------
// fir_peak_monitor
// watches both channels of the fir / peak block, keeps its own copy of the
// per-channel history and peak, predicts each result and compares field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fir_peak_monitor import firpk_pkg::*; #(
    parameter int CHANNELS  = 2,
    parameter int COEF_BITS = 18
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    firpk_in_if   i_in,
    firpk_out_if  i_out,
    output int    o_errors,
    output int    o_pending,
    output int    o_results,
    output int    o_blocks
);

    typedef struct {
        logic                    out_chan;
        logic signed [OUT_W-1:0] filtered;
        logic                    peak_valid;
        logic [PEAK_W-1:0]       peak_level;
        logic                    level_high;
    } t_fir_result;

    longint                     tap_coef [TAPS];
    logic signed [SAMPLE_W-1:0] hist [CHANNELS][TAPS];
    int                         hist_ptr [CHANNELS];
    logic [PEAK_W-1:0]          run_peak [CHANNELS];
    t_fir_result                expected_results [$];
    t_fir_result                want;
    int                         errors  = 0;
    int                         results = 0;
    int                         blocks  = 0;

    // coefficients rounded half up from q0.28, saturated to COEF_BITS
    initial begin
        int     m;
        int     s;
        longint c;
        longint lim;
        s   = 28 - (COEF_BITS - 1);
        lim = (longint'(1) << (COEF_BITS - 1)) - 1;
        for (int k = 0; k < TAPS; k++) begin
            m = (k <= TAPS / 2) ? k : TAPS - 1 - k;
            c = (longint'(COEF_Q28[m]) + (longint'(1) << (s - 1))) >>> s;
            if (c > lim) begin
                c = lim;
            end
            if (c < -lim - 1) begin
                c = -lim - 1;
            end
            tap_coef[k] = c;
        end
    end

    // filter over the earlier samples, then push the new one and update the peak
    function automatic t_fir_result filter_and_meter(input logic ch_in,
                                                     input logic signed [SAMPLE_W-1:0] smp,
                                                     input logic be);
        t_fir_result r;
        int          ch;
        int          ptr;
        int          idx;
        int          mag;
        longint      acc;
        longint      y;
        ch  = int'(ch_in) % CHANNELS;
        ptr = hist_ptr[ch];
        if (ptr >= TAPS) begin
            ptr = 0;
        end
        acc = 0;
        for (int k = 0; k < TAPS; k++) begin
            idx = ptr + k;
            if (idx >= TAPS) begin
                idx -= TAPS;
            end
            acc += tap_coef[k] * longint'(hist[ch][idx]);
        end
        y = (acc + (longint'(1) << (COEF_BITS - 2))) >>> (COEF_BITS - 1);
        if (y > OUT_MAX) begin
            y = OUT_MAX;
        end
        if (y < OUT_MIN) begin
            y = OUT_MIN;
        end

        hist[ch][ptr] = smp;
        hist_ptr[ch]  = (ptr + 1 >= TAPS) ? 0 : ptr + 1;

        // magnitude of the most negative sample clips to full scale
        mag = int'(smp);
        if (mag < 0) begin
            mag = -mag;
        end
        if (mag > (1 << PEAK_W) - 1) begin
            mag = (1 << PEAK_W) - 1;
        end
        if (mag > int'(run_peak[ch])) begin
            run_peak[ch] = mag[PEAK_W-1:0];
        end

        r.out_chan   = ch_in;
        r.filtered   = y[OUT_W-1:0];
        r.peak_valid = be;
        if (be) begin
            r.peak_level = run_peak[ch];
            r.level_high = (int'(run_peak[ch]) >= LEVEL_LIMIT);
            run_peak[ch] = '0;
        end else begin
            r.peak_level = '0;
            r.level_high = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic signed [31:0] want_v,
                                   input logic signed [31:0] got_v);
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want_v, got_v);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                for (int k = 0; k < TAPS; k++) begin
                    hist[c][k] = '0;
                end
                hist_ptr[c] = 0;
                run_peak[c] = '0;
            end
            expected_results.delete();
        end else begin
            // results first, so a result can never match a request of the same edge
            if (i_out.valid && i_out.ready) begin
                results++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with no request waiting, filtered %0d",
                             $time, i_out.filtered);
                end else begin
                    want = expected_results.pop_front();
                    if (want.peak_valid) begin
                        blocks++;
                    end
                    if (i_out.out_chan !== want.out_chan) begin
                        report_mismatch("out_chan", 32'(want.out_chan), 32'(i_out.out_chan));
                    end
                    if (i_out.filtered !== want.filtered) begin
                        report_mismatch("filtered", 32'(want.filtered), 32'(i_out.filtered));
                    end
                    if (i_out.peak_valid !== want.peak_valid) begin
                        report_mismatch("peak_valid", 32'(want.peak_valid),
                                        32'(i_out.peak_valid));
                    end
                    if (i_out.peak_level !== want.peak_level) begin
                        report_mismatch("peak_level", 32'(want.peak_level),
                                        32'(i_out.peak_level));
                    end
                    if (i_out.level_high !== want.level_high) begin
                        report_mismatch("level_high", 32'(want.level_high),
                                        32'(i_out.level_high));
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                expected_results.push_back(filter_and_meter(i_in.chan, i_in.sample,
                                                            i_in.block_end));
            end
        end
        o_errors  <= errors;
        o_pending <= expected_results.size();
        o_results <= results;
        o_blocks  <= blocks;
    end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// drives sample requests into the fir / peak block under several idle mixes,
// with a long output hold-off, and reports the verdict from the monitor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import firpk_pkg::*; ();

    localparam int HOLD_CYCLES  = 600;
    localparam int PHASE_ITEMS  = 175;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_served    = 0;
    int items_sent     = 0;

    int errors;
    int pending;
    int results;
    int blocks;

    int send_mix  [4] = '{0, 63, 0, 6};
    int stall_mix [4] = '{0, 0, 63, 6};

    firpk_in_if  in_if ();
    firpk_out_if out_if ();

    fir_lowpass_with_peak_level dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    fir_peak_monitor mon (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_if),
        .i_out     (out_if),
        .o_errors  (errors),
        .o_pending (pending),
        .o_results (results),
        .o_blocks  (blocks)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // entered and left at a falling edge
    task automatic send_request(input logic ch, input logic signed [SAMPLE_W-1:0] smp,
                                input logic be);
        int gap;
        gap = 0;
        if (send_idle_pct > 0 && $urandom_range(0, 15) == 0) begin
            gap = $urandom_range(1, 64);
        end
        while (gap > 0 || $urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
            if (gap > 0) begin
                gap--;
            end
        end
        in_if.valid     = 1'b1;
        in_if.chan      = ch;
        in_if.sample    = smp;
        in_if.block_end = be;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    // output side: random stalls, short bursts, and the long hold-off on request
    initial begin
        int hold_len;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_asked) begin
                out_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_served++;
            end else if (recv_stall_pct > 0 && $urandom_range(0, 31) == 0) begin
                out_if.ready = 1'b0;
                hold_len = $urandom_range(1, 64);
                repeat (hold_len) @(negedge i_clk);
            end
            out_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        int                         phase_start;
        int                         burst;
        int                         kind;
        int                         m;
        logic                       ch;
        logic                       pol;
        logic                       be;
        logic signed [SAMPLE_W-1:0] smp;

        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.chan      = 1'b0;
        in_if.sample    = '0;
        in_if.block_end = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: field extremes, peak clip, level threshold, empty blocks
        send_request(1'b0, 16'sd32767, 1'b0);
        send_request(1'b0, -16'sd32768, 1'b1);
        send_request(1'b1, 16'sd0, 1'b1);
        send_request(1'b1, 16'sd32113, 1'b1);
        send_request(1'b1, 16'sd32112, 1'b1);
        send_request(1'b0, -16'sd32113, 1'b1);
        send_request(1'b0, -16'sd32112, 1'b1);
        send_request(1'b0, -16'sd1, 1'b0);
        send_request(1'b0, 16'sd1, 1'b1);
        send_request(1'b1, -16'sd32767, 1'b0);
        send_request(1'b1, 16'sd100, 1'b1);
        send_request(1'b0, 16'sh5555, 1'b0);
        send_request(1'b1, 16'shAAAA, 1'b0);
        send_request(1'b0, 16'shAAAA, 1'b1);
        send_request(1'b1, 16'sh5555, 1'b1);
        send_request(1'b0, -16'sd32768, 1'b0);
        send_request(1'b0, -16'sd32768, 1'b0);
        send_request(1'b1, 16'sd32767, 1'b0);
        send_request(1'b0, 16'sd0, 1'b1);
        send_request(1'b1, 16'sd0, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = send_mix[phase];
            recv_stall_pct = stall_mix[phase];
            phase_start    = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if (phase == 0 && hold_asked == 0 && items_sent - phase_start >= 40) begin
                    hold_asked = 1;
                end
                kind = $urandom_range(0, 99);
                ch   = 1'($urandom_range(0, 1));
                if (kind < 4) begin
                    // history matched to the coefficient signs: largest output swing
                    pol = 1'($urandom_range(0, 1));
                    for (int j = 0; j < TAPS; j++) begin
                        m = (j <= TAPS / 2) ? j : TAPS - 1 - j;
                        if (COEF_Q28[m] > 0) begin
                            smp = pol ? -16'sd32768 : 16'sd32767;
                        end else if (COEF_Q28[m] < 0) begin
                            smp = pol ? 16'sd32767 : -16'sd32768;
                        end else begin
                            smp = 16'($urandom);
                        end
                        send_request(ch, smp, 1'b0);
                    end
                    smp = 16'($urandom);
                    send_request(ch, smp, 1'($urandom_range(0, 1)));
                end else begin
                    burst = $urandom_range(1, 20);
                    repeat (burst) begin
                        ch = 1'($urandom_range(0, 1));
                        if (kind < 60) begin
                            smp = 16'($urandom);
                            be  = ($urandom_range(0, 15) == 0);
                        end else if (kind < 80) begin
                            // around the high-level threshold
                            smp = 16'(LEVEL_LIMIT + $urandom_range(0, 4) - 2);
                            if ($urandom_range(0, 1)) begin
                                smp = -smp;
                            end
                            be = ($urandom_range(0, 2) == 0);
                        end else begin
                            case ($urandom_range(0, 5))
                                0: smp = 16'sd32767;
                                1: smp = -16'sd32768;
                                2: smp = 16'sd0;
                                3: smp = -16'sd1;
                                4: smp = 16'sd1;
                                default: smp = -16'sd32767;
                            endcase
                            be = ($urandom_range(0, 3) == 0);
                        end
                        send_request(ch, smp, be);
                    end
                end
            end
        end
        in_if.valid = 1'b0;

        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (64) @(posedge i_clk);

        $display("run covered %0d sample requests under four idle mixes and a %0d-cycle hold-off",
                 items_sent, HOLD_CYCLES);
        $display("%0d results checked, %0d block-end peak reports, %0d mismatches",
                 results, blocks, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
